[rtl/pi_valve_flow_controller_defines.svh]
// Assertion helpers for the controller RTL
`ifndef PI_VALVE_FLOW_CONTROLLER_DEFINES_SVH
`define PI_VALVE_FLOW_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PVFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pvfc check failed");

// Next-cycle implication, checked outside reset
`define PVFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pvfc check failed");

`endif

[rtl/pvfc_pkg.sv]
package pvfc_pkg;

  typedef enum logic [1:0] {
    DIR_FLOATING = 2'd0,
    DIR_EXTEND   = 2'd1,
    DIR_RETRACT  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    REG_P_GAIN        = 2'd0,
    REG_I_GAIN        = 2'd1,
    REG_REVERSE_SENSE = 2'd2
  } reg_idx_t;

  localparam logic [6:0]  FLOW_LIMIT     = 7'd100;
  localparam logic [11:0] P_GAIN_RESET   = 12'd256;
  localparam logic [11:0] I_GAIN_RESET   = 12'd0;
  localparam int          INTEGRAL_LIMIT = 100;

endpackage

[rtl/pi_valve_flow_controller.sv]
// PI valve flow controller with integral anti-windup. Each word carries a
// reference and a measured angle; the block returns one word with the valve
// direction (0 floating, 1 extend, 2 retract) and a flow magnitude saturated
// at 100. A zero error floats the valve and leaves the integral alone;
// otherwise the error is added to an integral held within +/-100. Gains are
// unsigned Q4.8 set over the APB port (p_gain at 0x0, i_gain at 0x4,
// reverse_sense at 0x8); write them only while the block is idle. One word is
// accepted every cycle while the result side does not stall: the input
// register feeds one pass of the error, integral update and two small
// multipliers into the result register, which presents the word's result
// until it is taken. The integral register is updated in that same pass,
// which lets the next word follow at once.
`include "pi_valve_flow_controller_defines.svh"

module pi_valve_flow_controller
  import pvfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_reference_angle,
  input  logic signed [15:0] in_measured_angle,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_drive_direction,
  output logic [6:0]         out_flow_command,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [11:0] p_gain_r;
  logic [11:0] i_gain_r;
  logic        rev_r;

  logic               s1_valid_r;
  logic signed [15:0] ref_r;
  logic signed [15:0] meas_r;

  logic signed [7:0]  integ_r;
  logic signed [7:0]  integ_nxt;

  logic               out_valid_r;
  dir_t               dir_r;
  dir_t               dir_nxt;
  logic [6:0]         flow_r;
  logic [6:0]         flow_nxt;

  logic               out_free;
  logic               s1_fire;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  logic signed [16:0] err;
  logic               err_zero;
  logic signed [17:0] integ_sum;
  logic signed [12:0] p_gain_s;
  logic signed [12:0] i_gain_s;
  logic signed [29:0] p_prod;
  logic signed [29:0] p_adj;
  logic signed [21:0] p_term;
  logic signed [21:0] integ_ext;
  logic signed [21:0] i_prod_a;
  logic signed [21:0] i_prod_b;
  logic signed [21:0] i_adj_a;
  logic signed [21:0] i_adj_b;
  logic signed [13:0] i_term_a;
  logic signed [13:0] i_term_b;
  logic signed [22:0] sum_a;
  logic signed [22:0] sum_b;
  logic signed [22:0] sum_sel;
  logic [22:0]        mag;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_P_GAIN:        prdata = {20'd0, p_gain_r};
      REG_I_GAIN:        prdata = {20'd0, i_gain_r};
      REG_REVERSE_SENSE: prdata = {31'd0, rev_r};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r <= P_GAIN_RESET;
      i_gain_r <= I_GAIN_RESET;
      rev_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_P_GAIN:        p_gain_r <= pwdata[11:0];
        REG_I_GAIN:        i_gain_r <= pwdata[11:0];
        REG_REVERSE_SENSE: rev_r    <= pwdata[0];
        default:           ;
      endcase
    end
  end

  // handshake: input register advances whenever the result register frees up
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ref_r  <= in_reference_angle;
      meas_r <= in_measured_angle;
    end
  end

  // error and clamped integral
  always_comb begin
    err       = {ref_r[15], ref_r} - {meas_r[15], meas_r};
    err_zero  = (err == 17'sd0);
    integ_sum = {{10{integ_r[7]}}, integ_r} + {err[16], err};
    if (integ_sum > 18'(INTEGRAL_LIMIT)) begin
      integ_nxt = 8'(INTEGRAL_LIMIT);
    end else if (integ_sum < -18'(INTEGRAL_LIMIT)) begin
      integ_nxt = -8'(INTEGRAL_LIMIT);
    end else begin
      integ_nxt = integ_sum[7:0];
    end
  end

  // P and I terms, each truncated toward zero after the Q4.8 product
  always_comb begin
    p_gain_s  = {1'b0, p_gain_r};
    i_gain_s  = {1'b0, i_gain_r};
    p_prod    = 30'(p_gain_s * err);
    p_adj     = p_prod + (p_prod[29] ? 30'sd255 : 30'sd0);
    p_term    = p_adj[29:8];
    integ_ext = {{14{integ_nxt[7]}}, integ_nxt};
    i_prod_a  = 22'(i_gain_s * integ_nxt);
    // boosted gain adds 1.5 = 384/256: shift-add instead of a third multiplier
    i_prod_b  = i_prod_a + (integ_ext <<< 8) + (integ_ext <<< 7);
    i_adj_a   = i_prod_a + (i_prod_a[21] ? 22'sd255 : 22'sd0);
    i_adj_b   = i_prod_b + (i_prod_b[21] ? 22'sd255 : 22'sd0);
    i_term_a  = i_adj_a[21:8];
    i_term_b  = i_adj_b[21:8];
    sum_a     = {p_term[21], p_term} + {{9{i_term_a[13]}}, i_term_a};
    sum_b     = {p_term[21], p_term} + {{9{i_term_b[13]}}, i_term_b};
  end

  // direction and saturated flow
  always_comb begin
    if (sum_a[22]) begin
      sum_sel = sum_a;
      dir_nxt = rev_r ? DIR_RETRACT : DIR_EXTEND;
    end else begin
      sum_sel = sum_b;
      dir_nxt = rev_r ? DIR_EXTEND : DIR_RETRACT;
    end
    mag = sum_sel[22] ? 23'(-sum_sel) : 23'(sum_sel);
    if (mag > {16'd0, FLOW_LIMIT}) begin
      flow_nxt = FLOW_LIMIT;
    end else begin
      flow_nxt = mag[6:0];
    end
    if (err_zero) begin
      dir_nxt  = DIR_FLOATING;
      flow_nxt = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= 8'sd0;
    end else if (s1_fire && !err_zero) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      dir_r  <= dir_nxt;
      flow_r <= flow_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_direction = dir_r;
  assign out_flow_command    = flow_r;

  `PVFC_ASSERT_NOW(a_integ_range, 1'b1, (integ_r <= 8'sd100) && (integ_r >= -8'sd100))
  `PVFC_ASSERT_NOW(a_flow_limit, out_valid_r, flow_r <= FLOW_LIMIT)
  `PVFC_ASSERT_NOW(a_float_no_flow, out_valid_r && (dir_r == DIR_FLOATING), flow_r == 7'd0)
  `PVFC_ASSERT_NEXT(a_integ_hold, !s1_fire, integ_r == $past(integ_r))

endmodule

[bench/valve_command_checker.sv]
module valve_command_checker
  import pvfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_reference_angle,
  input  logic signed [15:0] in_measured_angle,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_drive_direction,
  input  logic [6:0]         out_flow_command,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 outstanding
);

  localparam int GAIN_BOOST = 384;

  typedef struct packed {
    dir_t       dir;
    logic [6:0] flow;
  } valve_cmd_t;

  logic [11:0]        kp;
  logic [11:0]        ki;
  logic               reverse;
  logic signed [7:0]  integral;
  valve_cmd_t         pending_cmds[$];

  // Q4.8 gain times an integer; SV division truncates toward zero
  function automatic longint gain_product(input int gain, input int value);
    longint prod;
    prod = longint'(gain) * longint'(value);
    return prod / 256;
  endfunction

  function automatic valve_cmd_t predict_valve_cmd(input logic signed [15:0] ref_angle,
                                                   input logic signed [15:0] meas_angle);
    int         err;
    int         integ;
    longint     p_term;
    longint     total;
    valve_cmd_t cmd;
    err = int'(ref_angle) - int'(meas_angle);
    if (err == 0) begin
      cmd.dir  = DIR_FLOATING;
      cmd.flow = '0;
      return cmd;
    end
    integ = int'(integral) + err;
    if (integ > INTEGRAL_LIMIT) begin
      integ = INTEGRAL_LIMIT;
    end else if (integ < -INTEGRAL_LIMIT) begin
      integ = -INTEGRAL_LIMIT;
    end
    integral = integ[7:0];
    p_term = gain_product(int'(kp), err);
    total  = p_term + gain_product(int'(ki), integ);
    if (total < 0) begin
      cmd.dir = reverse ? DIR_RETRACT : DIR_EXTEND;
    end else begin
      // non-negative output: redo the integral term with the boosted gain
      total   = p_term + gain_product(int'(ki) + GAIN_BOOST, integ);
      cmd.dir = reverse ? DIR_EXTEND : DIR_RETRACT;
    end
    if (total < 0) begin
      total = -total;
    end
    if (total > longint'(FLOW_LIMIT)) begin
      total = longint'(FLOW_LIMIT);
    end
    cmd.flow = total[6:0];
    return cmd;
  endfunction

  always @(posedge clk) begin : watch
    valve_cmd_t  want;
    logic [31:0] reg_value;
    logic        mapped;
    if (!rst_n) begin
      kp          = P_GAIN_RESET;
      ki          = I_GAIN_RESET;
      reverse     = 1'b0;
      integral    = '0;
      pending_cmds.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      if (psel && penable && pready) begin
        mapped = 1'b1;
        case (paddr[3:2])
          REG_P_GAIN:        reg_value = {20'd0, kp};
          REG_I_GAIN:        reg_value = {20'd0, ki};
          REG_REVERSE_SENSE: reg_value = {31'd0, reverse};
          default:           mapped = 1'b0;
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_P_GAIN:        kp = pwdata[11:0];
            REG_I_GAIN:        ki = pwdata[11:0];
            REG_REVERSE_SENSE: reverse = pwdata[0];
            default:           ;
          endcase
        end else if (mapped && prdata !== reg_value) begin
          fail_count++;
          $display("%0t: register read at 0x%0h: expected 0x%0h, got 0x%0h",
                   $time, paddr, reg_value, prdata);
        end
      end
      if (in_valid && !in_stall) begin
        pending_cmds.push_back(predict_valve_cmd(in_reference_angle, in_measured_angle));
      end
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word: expected none, got dir %0d flow %0d",
                   $time, out_drive_direction, out_flow_command);
        end else begin
          want = pending_cmds.pop_front();
          if (out_drive_direction !== want.dir) begin
            fail_count++;
            $display("%0t: drive_direction: expected %0d, got %0d",
                     $time, want.dir, out_drive_direction);
          end
          if (out_flow_command !== want.flow) begin
            fail_count++;
            $display("%0t: flow_command: expected %0d, got %0d",
                     $time, want.flow, out_flow_command);
          end
        end
      end
      outstanding = pending_cmds.size();
    end
  end

endmodule

[bench/pi_valve_flow_controller_tb.sv]
module pi_valve_flow_controller_tb;
  import pvfc_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 6;
  localparam int         IDLE_CYCLES  = 4;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_reference_angle;
  logic signed [15:0] in_measured_angle;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_drive_direction;
  logic [6:0]         out_flow_command;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int outstanding;
  int cycles = 0;
  bit calm = 1'b0;

  pi_valve_flow_controller DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_reference_angle (in_reference_angle),
    .in_measured_angle  (in_measured_angle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_direction(out_drive_direction),
    .out_flow_command   (out_flow_command),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  valve_command_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_reference_angle (in_reference_angle),
    .in_measured_angle  (in_measured_angle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_direction(out_drive_direction),
    .out_flow_command   (out_flow_command),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, none once the run goes calm
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = wr;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_gains(input logic [11:0] kp, input logic [11:0] ki, input logic rev);
    logic [31:0] junk;
    // hold off until the pipeline has drained
    wait (outstanding == 0);
    repeat (IDLE_CYCLES) @(negedge clk);
    junk = $urandom;
    apb_access(1'b1, REG_P_GAIN, {junk[31:12], kp});
    junk = $urandom;
    apb_access(1'b1, REG_I_GAIN, {junk[31:12], ki});
    junk = $urandom;
    apb_access(1'b1, REG_REVERSE_SENSE, {junk[31:1], rev});
    // unmapped slot must not disturb anything
    apb_access(1'b1, REG_UNMAPPED, $urandom);
    apb_access(1'b0, REG_P_GAIN, '0);
    apb_access(1'b0, REG_I_GAIN, '0);
    apb_access(1'b0, REG_REVERSE_SENSE, '0);
  endtask

  task automatic put_word(input logic signed [15:0] ref_angle,
                          input logic signed [15:0] meas_angle);
    if (!calm && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid           = 1'b1;
    in_reference_angle = ref_angle;
    in_measured_angle  = meas_angle;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic run_random(input int count);
    logic signed [15:0] ref_angle;
    logic signed [15:0] meas_angle;
    int                 delta;
    repeat (count) begin
      ref_angle  = 16'($urandom);
      meas_angle = 16'($urandom);
      case ($urandom_range(0, 9))
        0: meas_angle = ref_angle;
        1, 2, 3: ;
        default: begin
          // tracking a nearby target keeps the error within +/-200
          ref_angle  = 16'(int'($urandom_range(0, 60000)) - 30000);
          delta      = int'($urandom_range(0, 400)) - 200;
          meas_angle = 16'(ref_angle - delta);
        end
      endcase
      put_word(ref_angle, meas_angle);
    end
  endtask

  function automatic logic [11:0] random_gain();
    if ($urandom_range(0, 3) == 0) begin
      return 12'($urandom_range(0, 4095));
    end
    return 12'($urandom_range(0, 600));
  endfunction

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_reference_angle = '0;
    in_measured_angle  = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    set_gains(P_GAIN_RESET, I_GAIN_RESET, 1'b0);
    put_word(16'sd0, 16'sd0);
    put_word(16'sd32767, 16'sd32767);
    put_word(-16'sd32768, -16'sd32768);
    put_word(16'sd32767, -16'sd32768);
    put_word(-16'sd32768, 16'sd32767);
    put_word(16'sd1, 16'sd0);
    put_word(16'sd0, 16'sd1);
    put_word(-16'sd1, 16'sd0);
    put_word(16'sd50, -16'sd50);
    put_word(-16'sd300, 16'sd0);

    set_gains(12'd4095, 12'd4095, 1'b1);
    put_word(16'sd32767, -16'sd32768);
    put_word(-16'sd32768, 16'sd32767);
    put_word(16'sd3, 16'sd0);
    put_word(16'sd0, 16'sd3);
    put_word(16'sd0, 16'sd0);

    // zero gains: only the boost term acts, and the integral is walked through zero
    set_gains(12'd0, 12'd0, 1'b0);
    put_word(-16'sd32768, 16'sd32767);
    put_word(16'sd105, 16'sd0);
    put_word(-16'sd5, 16'sd0);
    put_word(16'sd20, 16'sd0);
    put_word(-16'sd7, 16'sd0);

    set_gains(12'd0, 12'd4095, 1'b1);
    put_word(16'sh5555, 16'shAAAA);
    put_word(16'shAAAA, 16'sh5555);
    put_word(-16'sd1, 16'sd1);

    set_gains(12'd4095, 12'd0, 1'b0);
    run_random(95);
    repeat (3) begin
      set_gains(random_gain(), random_gain(), 1'($urandom_range(0, 1)));
      run_random(95);
    end
    set_gains(random_gain(), random_gain(), 1'($urandom_range(0, 1)));
    calm = 1'b1;
    run_random(95);

    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/pvfc_pkg.sv
rtl/pi_valve_flow_controller.sv
bench/valve_command_checker.sv
bench/pi_valve_flow_controller_tb.sv
